/* rtl/core/slfl_pkg.sv */
// Shared types and constants for the slot allocator with free list.
`default_nettype none

package slfl_pkg;

  // Default pool size handed to the top level parameter.
  localparam int unsigned POOL_SLOTS_DEF = 512;

  // Fixed field widths of the stream payloads.
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned RSV_W    = 10;
  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 16;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Commands from the allocator control to the free-list queue.
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  // Queue status seen by the allocator control.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/slfl_free_queue.sv */
// First-in first-out free list: memory, head and tail pointers, fill count.
`default_nettype none

module slfl_free_queue
  import slfl_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int unsigned AW         = $clog2(POOL_SLOTS),
  parameter int unsigned CW         = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire q_cmd_t        cmd,
  input  wire logic [AW-1:0] wdata,
  output q_stat_t            stat,
  output logic      [AW-1:0] head_slot
);

  localparam logic [AW-1:0] LAST_POS = AW'(POOL_SLOTS - 1);

  logic [AW-1:0] mem [POOL_SLOTS];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail;
  logic [AW-1:0] tail_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] rd_q;
  logic          byp_hit;
  logic [AW-1:0] byp_data;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (cmd.pop) begin
      head_next  = (head == LAST_POS) ? '0 : head + AW'(1);
      count_next = count - CW'(1);
    end
    if (cmd.push) begin
      tail_next  = (tail == LAST_POS) ? '0 : tail + AW'(1);
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // The oldest entry is read ahead at the next head position every cycle.
  // A push into that same position (queue empty) is forwarded.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= wdata;
    end
    rd_q     <= mem[head_next];
    byp_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= cmd.push && (tail == head_next);
    end
  end

  assign head_slot  = byp_hit ? byp_data : rd_q;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(POOL_SLOTS));

endmodule

`default_nettype wire

/* rtl/core/slot_allocator_fifo_free_list_top.sv */
// Top level of the slot allocator: stream ports, bump counter, result register.
`default_nettype none

// Hands out slot numbers from a pool of POOL_SLOTS entries. Each input transfer
// carries a request kind on s_tuser (0 allocate, 1 free) and returns exactly one
// result transfer. An allocate takes the oldest slot from a first-in first-out
// free list; when the list is empty it takes the next never-used slot from a bump
// counter, and when that counter has also reached the pool size the result says
// the pool is exhausted. A free queues slot_index only when it is below the bump
// counter (else status "out of range") and the list is not full (else status
// "list full"). Every result also carries limit_ok, which is set when the bump
// counter plus reserve_offset, taken before the request acts, is below the pool
// size. The block takes one transfer per clock cycle while its results are taken.
// A request passes from the input register to the result register; a stalled
// result holds the input register and, through it, s_tready. The oldest
// free-list entry is read ahead from the free-list memory every cycle so that an
// allocate finds it in a register, which is what keeps the rate at one per cycle.
// The free-list memory needs no clearing after reset; an entry is only used after
// it has been written.
module slot_allocator_fifo_free_list_top
  import slfl_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // slot_index[9:0], reserve_offset[19:10], zeros
  input  wire logic                s_tuser,  // mode
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata   // slot[8:0], status[10:9], limit_ok[11], zeros
);

  localparam int unsigned AW    = $clog2(POOL_SLOTS);
  localparam int unsigned CW    = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SUM_W = ((CW > IDX_W) ? CW : IDX_W) + 1;

  // Input register.
  logic             s1_valid;
  logic             s1_mode;
  logic [IDX_W-1:0] s1_idx;
  logic [RSV_W-1:0] s1_reserve;

  // Bump counter: number of never-used slots handed out so far.
  logic [CW-1:0] bump_count;

  // Result register.
  logic              out_limit;
  status_t           out_status;
  logic [SLOT_W-1:0] out_slot;

  logic advance;
  logic accept;

  q_cmd_t        q_cmd;
  q_stat_t       q_stat;
  logic [AW-1:0] head_slot;
  logic [AW-1:0] q_wdata;

  logic                 want_push;
  logic                 want_pop;
  logic                 bump_inc;
  logic [AW-1:0]        res_slot;
  status_t              res_status;
  logic                 limit_ok;
  logic [SUM_W-1:0]     limit_sum;
  logic                 idx_oob;
  logic                 bump_full;
  logic [AW+IDX_W-1:0]  idx_wide;
  logic [AW+SLOT_W-1:0] slot_wide;

  // The input register moves on whenever the result register is empty or
  // its content is being taken in this cycle.
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!s1_valid || advance);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode    <= s_tuser;
      s1_idx     <= s_tdata[IDX_W-1:0];
      s1_reserve <= s_tdata[IDX_W+RSV_W-1:IDX_W];
    end
  end

  // Decision for the request held in the input register. The sum is formed
  // wide enough that it never wraps.
  assign limit_sum = SUM_W'(bump_count) + SUM_W'(s1_reserve);
  assign limit_ok  = (limit_sum < SUM_W'(POOL_SLOTS));
  assign idx_oob   = (SUM_W'(s1_idx) >= SUM_W'(bump_count));
  assign bump_full = (bump_count == CW'(POOL_SLOTS));

  always_comb begin
    want_push  = 1'b0;
    want_pop   = 1'b0;
    bump_inc   = 1'b0;
    res_slot   = '0;
    res_status = ST_OK;
    if (!s1_mode) begin
      if (!q_stat.empty) begin
        want_pop = 1'b1;
        res_slot = head_slot;
      end else if (!bump_full) begin
        bump_inc = 1'b1;
        res_slot = bump_count[AW-1:0];
      end else begin
        res_status = ST_EXHAUSTED;
      end
    end else begin
      if (idx_oob) begin
        res_status = ST_RANGE;
      end else if (q_stat.full) begin
        res_status = ST_FULL;
      end else begin
        want_push = 1'b1;
      end
    end
  end

  // A queued index is below the bump counter, so it always fits the pointer width.
  assign idx_wide   = (AW + IDX_W)'(s1_idx);
  assign q_wdata    = idx_wide[AW-1:0];
  assign q_cmd.push = advance && want_push;
  assign q_cmd.pop  = advance && want_pop;

  slfl_free_queue #(
    .POOL_SLOTS (POOL_SLOTS),
    .AW         (AW),
    .CW         (CW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .wdata     (q_wdata),
    .stat      (q_stat),
    .head_slot (head_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_count <= '0;
    end else if (advance && bump_inc) begin
      bump_count <= bump_count + CW'(1);
    end
  end

  // The slot field is the low bits of the slot number for wide pools.
  assign slot_wide = (AW + SLOT_W)'(res_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_slot   <= slot_wide[SLOT_W-1:0];
      out_status <= res_status;
      out_limit  <= limit_ok;
    end
  end

  assign m_tdata = {(M_DATA_W - SLOT_W - STAT_W - 1)'(0), out_limit, out_status, out_slot};

endmodule

`default_nettype wire

/* rtl/core/slfl_checker.sv */
// Port-level checks for the slot allocator, bound to the top level.
`default_nettype none

module slfl_checker
  import slfl_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // A held result keeps its content until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Every failed request carries a zero slot.
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[10:9] != ST_OK) |-> (m_tdata[8:0] == '0))
    else $error("failed request returned a nonzero slot");

  // An exhausted pool means the bump counter is at the pool size, so no reserve fits.
  a_exhausted_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[10:9] == ST_EXHAUSTED) |-> !m_tdata[11])
    else $error("limit_ok set with exhausted pool");

  // A result after an empty output stage came from an input transfer via the input register.
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a matching input transfer");

endmodule

bind slot_allocator_fifo_free_list_top slfl_checker u_slfl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
